FILE: rtl/core/kss_pkg.sv
// Package for the k-smallest selection unit.
// Holds widths, register decode, reset values and the cell control struct.
// No dependencies.
`default_nettype none

package kss_pkg;

	// Data path width of one value.
	localparam int DATA_W = 32;

	// Width of the keep_count register.
	localparam int CFG_W = 7;

	// Default build size of the cell chain.
	localparam int DEF_MAX_KEEP = 64;

	// Reset value of keep_count.
	localparam logic [CFG_W-1:0] KEEP_RESET = 7'd16;

	// APB address width and register index of keep_count (index sits at paddr[2]).
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_KEEP_COUNT = 1'b0;

	// Commands broadcast to every cell of the chain.
	typedef struct packed {
		logic insert;
		logic shift;
		logic clear;
	} cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/kss_in_if.sv
// Input channel interface of the k-smallest selection unit.
// Carries one sample per transfer with its final-item mark; uses kss_pkg.
`default_nettype none

interface kss_in_if
	import kss_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sample;
	logic                     final_item;

	modport source (output valid, output sample, output final_item, input ready);
	modport sink (input valid, input sample, input final_item, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/kss_out_if.sv
// Result channel interface of the k-smallest selection unit.
// Carries one chosen value per transfer with run-end and error marks; uses kss_pkg.
`default_nettype none

interface kss_out_if
	import kss_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] chosen;
	logic                     run_end;
	logic                     too_few;

	modport source (output valid, output chosen, output run_end, output too_few, input ready);
	modport sink (input valid, input chosen, input run_end, input too_few, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/kss_cell.sv
// One cell of the sorted insertion chain.
// Holds one kept value, compares it to the broadcast sample and trades with
// its neighbors; uses kss_pkg.
`default_nettype none

module kss_cell
	import kss_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cell_ctrl_t               ctrl,
	input  wire logic                     in_range,
	input  wire logic signed [DATA_W-1:0] sample,
	input  wire logic                     prev_gt,
	input  wire logic signed [DATA_W-1:0] prev_val,
	input  wire logic                     prev_valid,
	input  wire logic signed [DATA_W-1:0] next_val,
	input  wire logic                     next_valid,
	output logic signed [DATA_W-1:0]      val,
	output logic                          valid,
	output logic                          gt
);

	logic signed [DATA_W-1:0] val_q;
	logic                     valid_q;

	// A free cell or a larger kept value makes room for the sample here.
	assign gt    = !valid_q || (val_q > sample);
	assign val   = val_q;
	assign valid = valid_q;

	// Occupancy: clear wins, then drain shift, then insertion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_valid;
		end else if (ctrl.insert) begin
			if (gt) begin
				valid_q <= in_range && (prev_gt ? prev_valid : 1'b1);
			end else begin
				valid_q <= in_range && valid_q;
			end
		end
	end

	// Stored value follows the same moves; it needs no reset.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			val_q <= next_val;
		end else if (ctrl.insert && gt) begin
			val_q <= prev_gt ? prev_val : sample;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/k_smallest_select_unit.sv
// k-smallest selection unit: a sorted chain of compare cells with a drain sequencer.
// Top level; uses kss_pkg, kss_in_if, kss_out_if and kss_cell.
//
// Usage:
//   item   : input channel, one signed sample per transfer, final_item on the
//            last sample of a data set.
//   result : output channel, the kept values in ascending order, run_end on the
//            last one; a set with fewer than keep_count values gives a single
//            result with too_few set, chosen zero and run_end set.
//   APB    : keep_count at byte address 0; the user must write it only while idle
//            (not enforced). Zero acts as one, values above MAX_KEEP act as MAX_KEEP.
// Throughput: within a set one sample is taken every cycle; each sample is written
//   into the cell chain on its transfer by a broadcast compare in every cell.
// Sequence: after the final sample, a check state, then k drain steps, one
//   result per cycle while the output is not held, through the output register,
//   where k is the effective keep_count. The too_few case loads its single result
//   in the check state. The item channel is held off during the check and drain.
// Stalls: a held result keeps the output register full and freezes the drain.
// Reset: all cells empty, keep_count returns to 16, no result pending.
`default_nettype none

module k_smallest_select_unit
	import kss_pkg::*;
#(
	parameter int MAX_KEEP = DEF_MAX_KEEP
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	kss_in_if.sink                     item,
	kss_out_if.source                  result,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready
);

	localparam int KW = $clog2(MAX_KEEP + 1);
	localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DRAIN
	} state_t;

	state_t                   state_q;
	logic [CFG_W-1:0]         keep_q;
	logic [KW-1:0]            k_eff;
	logic [KW-1:0]            k_last;
	logic [KW-1:0]            remain_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] chosen_q;
	logic                     run_end_q;
	logic                     too_few_q;
	logic                     out_free;
	logic                     out_load;
	logic                     item_xfer;
	logic                     cfg_wr;
	cell_ctrl_t               ctrl;

	logic signed [DATA_W-1:0] cell_val [MAX_KEEP];
	logic [MAX_KEEP-1:0]      cell_valid;
	logic [MAX_KEEP-1:0]      cell_gt;
	logic [MAX_KEEP-1:0]      in_range;

	// Configuration port: writes complete in the access phase, no wait states.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= KEEP_RESET;
		end else if (cfg_wr && (paddr[2] == REG_KEEP_COUNT)) begin
			keep_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_KEEP_COUNT) begin
			prdata = {{(APB_DATA_W - CFG_W){1'b0}}, keep_q};
		end
	end

	// Effective k: zero acts as one, large values clip to the chain length.
	always_comb begin
		if (keep_q == '0) begin
			k_eff = KW'(1);
		end else if ({1'b0, keep_q} > (CFG_W + 1)'(MAX_KEEP)) begin
			k_eff = KW'(MAX_KEEP);
		end else begin
			k_eff = KW'(keep_q);
		end
	end
	assign k_last = k_eff - KW'(1);

	// Handshakes and cell commands.
	assign item.ready = (state_q == ST_IDLE);
	assign item_xfer  = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;

	// The output register takes a result in the too_few check and in every drain step.
	assign out_load = out_free && (((state_q == ST_CHECK) && !cell_valid[k_last[IW-1:0]])
		|| (state_q == ST_DRAIN));

	always_comb begin
		ctrl.insert = item_xfer;
		ctrl.shift  = (state_q == ST_DRAIN) && out_free;
		ctrl.clear  = out_free && (((state_q == ST_CHECK) && !cell_valid[k_last[IW-1:0]])
			|| ((state_q == ST_DRAIN) && (remain_q == KW'(1))));
	end

	// The chain of cells, cell 0 holding the smallest value.
	for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
		logic signed [DATA_W-1:0] prev_val_w;
		logic                     prev_valid_w;
		logic                     prev_gt_w;
		logic signed [DATA_W-1:0] next_val_w;
		logic                     next_valid_w;

		assign in_range[i] = (KW'(i) < k_eff);

		if (i == 0) begin : g_head
			assign prev_val_w   = '0;
			assign prev_valid_w = 1'b0;
			assign prev_gt_w    = 1'b0;
		end else begin : g_body
			assign prev_val_w   = cell_val[i-1];
			assign prev_valid_w = cell_valid[i-1];
			assign prev_gt_w    = cell_gt[i-1];
		end

		if (i == MAX_KEEP - 1) begin : g_tail
			assign next_val_w   = '0;
			assign next_valid_w = 1'b0;
		end else begin : g_link
			assign next_val_w   = cell_val[i+1];
			assign next_valid_w = cell_valid[i+1];
		end

		kss_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.in_range   (in_range[i]),
			.sample     (item.sample),
			.prev_gt    (prev_gt_w),
			.prev_val   (prev_val_w),
			.prev_valid (prev_valid_w),
			.next_val   (next_val_w),
			.next_valid (next_valid_w),
			.val        (cell_val[i]),
			.valid      (cell_valid[i]),
			.gt         (cell_gt[i])
		);
	end

	// Sequencer with the output register: check after the final sample, then drain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			remain_q    <= '0;
			out_valid_q <= 1'b0;
			chosen_q    <= '0;
			run_end_q   <= 1'b0;
			too_few_q   <= 1'b0;
		end else begin
			if (result.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_xfer && item.final_item) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (!cell_valid[k_last[IW-1:0]]) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							chosen_q    <= '0;
							run_end_q   <= 1'b1;
							too_few_q   <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end else begin
						remain_q <= k_eff;
						state_q  <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						chosen_q    <= cell_val[0];
						run_end_q   <= (remain_q == KW'(1));
						too_few_q   <= 1'b0;
						remain_q    <= remain_q - KW'(1);
						if (remain_q == KW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid   = out_valid_q;
	assign result.chosen  = chosen_q;
	assign result.run_end = run_end_q;
	assign result.too_few = too_few_q;

	// The error result is always a lone zero that closes the run.
	a_too_few_form: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.too_few) |-> (result.run_end && (result.chosen == '0)))
		else $error("too_few result without run_end or with nonzero value");

	// Occupied cells always form an unbroken run from the head of the chain.
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_valid & (cell_valid + MAX_KEEP'(1))) == '0))
		else $error("gap in the occupied cells of the chain");

	// While draining, a value is waiting at the head and results remain.
	a_drain_filled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (cell_valid[0] && (remain_q != '0)))
		else $error("drain with empty head cell or no results left");

endmodule

`default_nettype wire
